// ----- design/lsup_pkg.sv -----
// Shared types, codes and reset values for the link supervisor.
package lsup_pkg;

  localparam int unsigned TimeW = 32;

  typedef enum logic [2:0] {
    MODE_BOOT         = 3'd0,
    MODE_POST         = 3'd1,
    MODE_HANDSHAKE    = 3'd2,
    MODE_RUNNING      = 3'd3,
    MODE_ESTOP        = 3'd4,
    MODE_DISCONNECTED = 3'd5
  } mode_t;

  localparam logic [2:0] REQ_TICK  = 3'd0;
  localparam logic [2:0] REQ_FRAME = 3'd1;
  localparam logic [2:0] REQ_ESTOP = 3'd2;
  localparam logic [2:0] REQ_CLEAR = 3'd3;
  localparam logic [2:0] REQ_SET   = 3'd4;

  localparam logic [2:0] REG_DISCONNECT_TIMEOUT  = 3'd0;
  localparam logic [2:0] REG_HEARTBEAT_PERIOD    = 3'd1;
  localparam logic [2:0] REG_HEARTBEAT_ON_TIME   = 3'd2;
  localparam logic [2:0] REG_POST_BLINK          = 3'd3;
  localparam logic [2:0] REG_HANDSHAKE_BLINK     = 3'd4;
  localparam logic [2:0] REG_ESTOP_BLINK         = 3'd5;
  localparam logic [2:0] REG_DISCONNECTED_BLINK  = 3'd6;

  localparam logic [TimeW-1:0] RST_DISCONNECT_TIMEOUT = 32'd5000;
  localparam logic [TimeW-1:0] RST_HEARTBEAT_PERIOD   = 32'd2000;
  localparam logic [TimeW-1:0] RST_HEARTBEAT_ON_TIME  = 32'd50;
  localparam logic [TimeW-1:0] RST_POST_BLINK         = 32'd100;
  localparam logic [TimeW-1:0] RST_HANDSHAKE_BLINK    = 32'd500;
  localparam logic [TimeW-1:0] RST_ESTOP_BLINK        = 32'd50;
  localparam logic [TimeW-1:0] RST_DISCONNECTED_BLINK = 32'd150;

  typedef struct packed {
    logic [TimeW-1:0] disconnect_timeout;
    logic [TimeW-1:0] heartbeat_period;
    logic [TimeW-1:0] heartbeat_on_time;
    logic [TimeW-1:0] post_blink_period;
    logic [TimeW-1:0] handshake_blink_period;
    logic [TimeW-1:0] estop_blink_period;
    logic [TimeW-1:0] disconnected_blink_period;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       req_type;
    logic [TimeW-1:0] now_ms;
    logic [2:0]       new_mode;
  } item_t;

  typedef struct packed {
    mode_t mode;
    logic  led_on;
    logic  homing_start;
    logic  stop_all;
    logic  clear_stop;
  } res_t;

endpackage

// ----- design/lsup_cfg_regs.sv -----
// Configuration register file: timeout and LED timing registers.
module lsup_cfg_regs
  import lsup_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [TimeW-1:0] cfg_wdata,
  output cfg_t             cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.disconnect_timeout        <= RST_DISCONNECT_TIMEOUT;
      cfg.heartbeat_period          <= RST_HEARTBEAT_PERIOD;
      cfg.heartbeat_on_time         <= RST_HEARTBEAT_ON_TIME;
      cfg.post_blink_period         <= RST_POST_BLINK;
      cfg.handshake_blink_period    <= RST_HANDSHAKE_BLINK;
      cfg.estop_blink_period        <= RST_ESTOP_BLINK;
      cfg.disconnected_blink_period <= RST_DISCONNECTED_BLINK;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DISCONNECT_TIMEOUT: cfg.disconnect_timeout        <= cfg_wdata;
        REG_HEARTBEAT_PERIOD:   cfg.heartbeat_period          <= cfg_wdata;
        REG_HEARTBEAT_ON_TIME:  cfg.heartbeat_on_time         <= cfg_wdata;
        REG_POST_BLINK:         cfg.post_blink_period         <= cfg_wdata;
        REG_HANDSHAKE_BLINK:    cfg.handshake_blink_period    <= cfg_wdata;
        REG_ESTOP_BLINK:        cfg.estop_blink_period        <= cfg_wdata;
        REG_DISCONNECTED_BLINK: cfg.disconnected_blink_period <= cfg_wdata;
        default: ;
      endcase
    end
  end

endmodule

// ----- design/lsup_core.sv -----
// Supervisor state and per-event update: mode, frame time, LED phase.
module lsup_core
  import lsup_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  input  logic  fire,
  input  item_t item,
  input  cfg_t  cfg,
  output res_t  res
);

  mode_t            mode_reg, mode_next;
  logic [TimeW-1:0] last_frame_time, last_frame_time_next;
  logic [TimeW-1:0] led_change_time, led_change_time_next;
  logic             heartbeat_phase, heartbeat_phase_next;
  logic             led_level, led_level_next;

  logic [TimeW-1:0] rx_gap, led_elapsed, blink_period;
  logic             link_lost;
  mode_t            tick_mode;

  // wrapping differences
  assign rx_gap      = item.now_ms - last_frame_time;
  assign led_elapsed = item.now_ms - led_change_time;
  assign link_lost   = (mode_reg == MODE_RUNNING) && (rx_gap > cfg.disconnect_timeout);
  assign tick_mode   = link_lost ? MODE_DISCONNECTED : mode_reg;

  always_comb begin
    case (tick_mode)
      MODE_POST:         blink_period = cfg.post_blink_period;
      MODE_HANDSHAKE:    blink_period = cfg.handshake_blink_period;
      MODE_ESTOP:        blink_period = cfg.estop_blink_period;
      MODE_DISCONNECTED: blink_period = cfg.disconnected_blink_period;
      default:           blink_period = '0;
    endcase
  end

  always_comb begin
    mode_next            = mode_reg;
    last_frame_time_next = last_frame_time;
    led_change_time_next = led_change_time;
    heartbeat_phase_next = heartbeat_phase;
    led_level_next       = led_level;
    res.homing_start     = 1'b0;
    res.stop_all         = 1'b0;
    res.clear_stop       = 1'b0;
    case (item.req_type)
      REQ_TICK: begin
        mode_next        = tick_mode;
        res.homing_start = link_lost;
        // LED runs off the mode after a possible disconnect on this tick
        case (tick_mode)
          MODE_BOOT: led_level_next = 1'b1;
          MODE_RUNNING: begin
            if (!heartbeat_phase) begin
              if (led_elapsed >= cfg.heartbeat_period) begin
                led_level_next       = 1'b1;
                led_change_time_next = item.now_ms;
                heartbeat_phase_next = 1'b1;
              end
            end else if (led_elapsed >= cfg.heartbeat_on_time) begin
              // flash end keeps change time so flash starts stay periodic
              led_level_next       = 1'b0;
              heartbeat_phase_next = 1'b0;
            end
          end
          default: begin
            if (led_elapsed >= blink_period) begin
              led_level_next       = ~led_level;
              led_change_time_next = item.now_ms;
            end
          end
        endcase
      end
      REQ_FRAME: begin
        last_frame_time_next = item.now_ms;
        if (mode_reg == MODE_DISCONNECTED) mode_next = MODE_HANDSHAKE;
      end
      REQ_ESTOP: begin
        res.stop_all = 1'b1;
        mode_next    = MODE_ESTOP;
      end
      REQ_CLEAR: begin
        res.clear_stop = 1'b1;
        mode_next      = MODE_RUNNING;
      end
      REQ_SET: begin
        if (item.new_mode <= MODE_DISCONNECTED) mode_next = mode_t'(item.new_mode);
      end
      default: ;
    endcase
    res.mode   = mode_next;
    res.led_on = led_level_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_reg        <= MODE_POST;
      last_frame_time <= '0;
      led_change_time <= '0;
      heartbeat_phase <= 1'b0;
      led_level       <= 1'b1;
    end else if (fire) begin
      mode_reg        <= mode_next;
      last_frame_time <= last_frame_time_next;
      led_change_time <= led_change_time_next;
      heartbeat_phase <= heartbeat_phase_next;
      led_level       <= led_level_next;
    end
  end

endmodule

// ----- design/link_supervisor_with_status_led_top.sv -----
// Top level of the link supervisor: input register, update core, result register.
// One result comes out for every event beat. Events are taken one per clock
// with no bubbles while out_ready stays high; a beat passes through an input
// register and then the result register, where its result is offered. The rate
// is set by the state update in the core, which sees the state left by the
// previous beat. The input side keeps accepting while a result waits,
// stalling only when both the input and result registers are full.
module link_supervisor_with_status_led_top
  import lsup_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [2:0]       req_type,
  input  logic [TimeW-1:0] now_ms,
  input  logic [2:0]       new_mode,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [2:0]       mode,
  output logic             led_on,
  output logic             homing_start,
  output logic             stop_all,
  output logic             clear_stop,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [TimeW-1:0] cfg_wdata
);

  cfg_t  cfg;
  item_t item;
  res_t  res, res_q;
  logic  item_valid;
  logic  advance, fire, in_accept;

  assign advance   = !out_valid || out_ready;
  assign fire      = item_valid && advance;
  assign in_ready  = !item_valid || advance;
  assign in_accept = in_valid && in_ready;

  lsup_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  lsup_core u_core (
    .clk  (clk),
    .rst  (rst),
    .fire (fire),
    .item (item),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (in_accept)    item_valid <= 1'b1;
      else if (advance) item_valid <= 1'b0;
      if (fire)           out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item.req_type <= req_type;
      item.now_ms   <= now_ms;
      item.new_mode <= new_mode;
    end
    if (fire) res_q <= res;
  end

  assign mode         = res_q.mode;
  assign led_on       = res_q.led_on;
  assign homing_start = res_q.homing_start;
  assign stop_all     = res_q.stop_all;
  assign clear_stop   = res_q.clear_stop;

  a_one_pulse: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> $onehot0({homing_start, stop_all, clear_stop}))
    else $error("more than one command pulse in a result");

  a_homing_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && homing_start) |-> (mode == MODE_DISCONNECTED))
    else $error("homing pulse without disconnected mode");

  a_stop_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && stop_all) |-> (mode == MODE_ESTOP))
    else $error("stop pulse without estop mode");

  a_clear_mode: assert property (@(posedge clk) disable iff (rst)
    (out_valid && clear_stop) |-> (mode == MODE_RUNNING))
    else $error("clear pulse without running mode");

  a_boot_led: assert property (@(posedge clk) disable iff (rst)
    (out_valid && mode == MODE_BOOT && homing_start == 1'b0 && led_on == 1'b0)
      |-> (stop_all == 1'b0))
    else $error("boot result with LED off carries a stop pulse");

endmodule
